### rtl/sap_pkg.sv
package sap_pkg;

    // Width of the delay register as the configuration port sees it.
    localparam int DELAY_BITS = 12;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_COEFF    = 2'd2;

endpackage

### rtl/sap_ring_ram.sv
module sap_ring_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/schroeder_allpass_filter_unit.sv
// Schroeder allpass filter: y = -g*x + x[n-D] + g*y[n-D], one sample per beat.
//
// Input beats arrive on s_valid / s_ready with the sample on s_sample_in; result
// beats leave on m_valid / m_ready with the sample on m_sample_out. Every input
// beat produces exactly one result beat, in order.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes filter_enable,
// delay_samples and gain_coeff; the delay and gain are clamped to their legal
// ranges as they are written. Write it only while the block is idle.
//
// A beat goes through the processing stage, then the output register; a new beat
// is taken every cycle unless the receiver stalls. The delayed input and output
// samples sit in one dual-port ring memory with a registered read; the prior beat
// is still being written while the current one reads, so its values are forwarded.
// Feedback from y[n-D] to y[n] closes in the processing stage via one multiplier.
//
// Reset clears the pointer and a wrap flag; ring entries that were never written
// read as zero, so no clearing pass is needed and beats are taken right away.
// When the receiver stalls, the output register holds its beat and one more beat
// is absorbed in the processing stage before s_ready drops.
module schroeder_allpass_filter_unit #(
    parameter int RING_DEPTH     = 4096,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 15,
    localparam int CFG_BITS = ((GAIN_FRAC_BITS + 1) > sap_pkg::DELAY_BITS) ?
                              (GAIN_FRAC_BITS + 1) : sap_pkg::DELAY_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [sap_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]                  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out
);
    import sap_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
    localparam int GB = GAIN_FRAC_BITS + 1;
    localparam int PW = GB + SAMPLE_BITS;          // full product width
    localparam int RW = PW + 1 - GAIN_FRAC_BITS;   // rounded product width
    localparam int SW = RW + 1;                    // width of the three-term sum

    localparam logic signed [GB-1:0] GAIN_LIMIT =
        GB'((64'd999 << GAIN_FRAC_BITS) / 64'd1000);
    localparam logic signed [GB-1:0] GAIN_RESET =
        GB'((64'd7 * (64'd1 << GAIN_FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [PW:0] ROUND_HALF = (PW + 1)'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(RING_DEPTH);

    // Configuration registers, stored already clamped.
    logic                   enable_reg;
    logic [AW-1:0]          delay_reg;
    logic signed [GB-1:0]   gain_reg;
    logic signed [GB-1:0]   ngain_reg;
    logic [AW-1:0]          delay_next;
    logic signed [GB-1:0]   gain_next;

    // Ring pointer and the flag that tells whether every entry has been written.
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          wp_next;
    logic                   wrapped_reg;

    // Processing stage.
    logic                   p1_valid_reg;
    logic signed [PW-1:0]   p1_prod_x_reg;
    logic signed [SAMPLE_BITS-1:0] p1_x_reg;
    logic [AW-1:0]          p1_wp_reg;
    logic                   p1_fwd_reg;
    logic                   p1_written_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_x_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_y_reg;

    // Output register.
    logic                   m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;

    logic                   accept;
    logic                   p1_advance;
    logic [AW:0]            rp_wide;
    logic [AW-1:0]          rd_addr;
    logic                   rd_written;
    logic                   fwd_next;
    logic                   mem_we;
    logic [2*SAMPLE_BITS-1:0] mem_rdata;
    logic signed [PW-1:0]   prod_x;
    logic signed [SAMPLE_BITS-1:0] xd;
    logic signed [SAMPLE_BITS-1:0] yd;
    logic signed [PW-1:0]   prod_y;
    logic [PW:0]            rnd_x_sum;
    logic [PW:0]            rnd_y_sum;
    logic signed [RW-1:0]   rx;
    logic signed [RW-1:0]   ry;
    logic signed [SW-1:0]   sum;
    logic signed [SAMPLE_BITS-1:0] y_result;

    //------------------------------------------------------------------
    // Configuration. The delay is clamped to 1..RING_DEPTH-1 and the gain
    // to plus or minus GAIN_LIMIT as they are written, so the datapath
    // never has to look at raw register values.
    //------------------------------------------------------------------
    always_comb begin
        logic [CW-1:0]        d_wide;
        logic signed [GB-1:0] g_raw;
        d_wide = CW'(cfg_wdata[DELAY_BITS-1:0]);
        g_raw  = $signed(cfg_wdata[GB-1:0]);
        if (d_wide == '0) begin
            delay_next = AW'(1);
        end else if (d_wide > CW'(RING_DEPTH - 1)) begin
            delay_next = AW'(RING_DEPTH - 1);
        end else begin
            delay_next = AW'(d_wide);
        end
        if (g_raw > GAIN_LIMIT) begin
            gain_next = GAIN_LIMIT;
        end else if (g_raw < -GAIN_LIMIT) begin
            gain_next = -GAIN_LIMIT;
        end else begin
            gain_next = g_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            delay_reg  <= AW'(1);
            gain_reg   <= GAIN_RESET;
            ngain_reg  <= -GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FILTER_ENABLE: begin
                    enable_reg <= cfg_wdata[0];
                end
                CFG_DELAY_SAMPLES: begin
                    delay_reg <= delay_next;
                end
                CFG_GAIN_COEFF: begin
                    gain_reg  <= gain_next;
                    ngain_reg <= -gain_next;
                end
                default: begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Handshake. The processing stage moves on whenever the output
    // register is empty or being emptied; a new beat enters whenever the
    // processing stage is empty or moving on.
    //------------------------------------------------------------------
    assign p1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;

    //------------------------------------------------------------------
    // Read address: D entries behind the write pointer, modulo the depth.
    // Entries at or above the pointer before the first wrap were never
    // written and read as zero. The beat in the processing stage writes its
    // entry at this very edge, so a read of that entry takes its values
    // from the stage instead of the memory.
    //------------------------------------------------------------------
    assign wp_next = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign rp_wide = {1'b0, wp_reg} + DEPTH_W - {1'b0, delay_reg};
    assign rd_addr = (rp_wide >= DEPTH_W) ? AW'(rp_wide - DEPTH_W) : AW'(rp_wide);
    assign rd_written = wrapped_reg || (rd_addr < wp_reg);
    assign fwd_next   = p1_valid_reg && (rd_addr == p1_wp_reg);

    // The feed-forward product only needs the new sample, so it is formed
    // before the ring data arrives.
    assign prod_x = ngain_reg * s_sample_in;

    assign mem_we = p1_valid_reg && p1_advance && enable_reg;

    sap_ring_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (2 * SAMPLE_BITS)
    ) u_ring (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (p1_wp_reg),
        .wdata ({p1_x_reg, y_result}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    //------------------------------------------------------------------
    // Processing stage: pick the delayed samples, form the feedback product,
    // round both products half up, add and saturate, or pass x when disabled.
    //------------------------------------------------------------------
    always_comb begin
        if (p1_fwd_reg) begin
            xd = fwd_x_reg;
            yd = fwd_y_reg;
        end else if (p1_written_reg) begin
            xd = $signed(mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            yd = $signed(mem_rdata[SAMPLE_BITS-1:0]);
        end else begin
            xd = '0;
            yd = '0;
        end
    end

    assign prod_y    = gain_reg * yd;
    assign rnd_x_sum = {p1_prod_x_reg[PW-1], p1_prod_x_reg} + ROUND_HALF;
    assign rnd_y_sum = {prod_y[PW-1], prod_y} + ROUND_HALF;
    assign rx        = $signed(rnd_x_sum[PW:GAIN_FRAC_BITS]);
    assign ry        = $signed(rnd_y_sum[PW:GAIN_FRAC_BITS]);
    assign sum       = SW'(rx) + SW'(xd) + SW'(ry);

    always_comb begin
        if (!enable_reg) begin
            y_result = p1_x_reg;
        end else if (sum > SAT_MAX) begin
            y_result = SAMPLE_BITS'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            y_result = SAMPLE_BITS'(SAT_MIN);
        end else begin
            y_result = SAMPLE_BITS'(sum);
        end
    end

    //------------------------------------------------------------------
    // Control registers.
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                p1_valid_reg <= accept;
            end
            if (p1_advance) begin
                m_valid_reg <= p1_valid_reg;
            end
            // In pass-through mode the rings and the pointer stay untouched.
            if (accept && enable_reg) begin
                wp_reg <= wp_next;
                if (wp_reg == AW'(RING_DEPTH - 1)) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Payload registers.
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_prod_x_reg  <= prod_x;
            p1_x_reg       <= s_sample_in;
            p1_wp_reg      <= wp_reg;
            p1_fwd_reg     <= fwd_next;
            p1_written_reg <= rd_written;
            fwd_x_reg      <= p1_x_reg;
            fwd_y_reg      <= y_result;
        end
        if (p1_valid_reg && p1_advance) begin
            m_sample_reg <= y_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
    a_wp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg < AW'(RING_DEPTH - 1) || wp_reg == AW'(RING_DEPTH - 1))
        else $error("write pointer outside the ring");

    a_no_self_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && enable_reg) |-> (rd_addr != wp_reg))
        else $error("ring read hits the entry about to be written");

    a_fwd_source_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && enable_reg && fwd_next) |-> mem_we)
        else $error("forwarded values come from a beat that is not written");

    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && enable_reg) |=> $stable(wp_reg))
        else $error("write pointer moved without an enabled input beat");

endmodule

### tb/sv/tb_schroeder_allpass_filter_unit.sv
`timescale 1ns / 100ps

module tb_schroeder_allpass_filter_unit;
    import sap_pkg::*;

    localparam int RING_DEPTH     = 4096;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int CFG_BITS       = GAIN_FRAC_BITS + 1;

    // Index 3 maps to no register; a write there must leave everything alone.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam longint GAIN_LIMIT = 32735;
    localparam logic [CFG_BITS-1:0] GAIN_RESET = 16'd22938;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;

    schroeder_allpass_filter_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // 20 ns clock period.
    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Filter model. It keeps its own copy of both delay rings, the write
    // pointer and the three registers, and is stepped once per input beat.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] x_ring [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] y_ring [RING_DEPTH];
    logic [11:0]                   ring_wr_ptr;
    logic                          filt_en;
    logic [11:0]                   filt_delay;
    logic signed [CFG_BITS-1:0]    filt_gain;

    initial begin
        foreach (x_ring[i]) begin
            x_ring[i] = '0;
            y_ring[i] = '0;
        end
        ring_wr_ptr = '0;
        filt_en     = 1'b0;
        filt_delay  = 12'd1;
        filt_gain   = GAIN_RESET;
    end

    // Scale a sample-by-gain product back to Q1.23, rounding half up.
    function automatic longint round_to_sample(input longint p);
        return (p + (64'sd1 <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] allpass_next(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic [11:0] d;
        logic [11:0] rd_ptr;
        longint      g;
        longint      y;
        // Disabled: straight pass-through, rings and pointer untouched.
        if (!filt_en) return x;
        // A delay of zero acts as one; the top value is already DEPTH-1.
        d = (filt_delay == 12'd0) ? 12'd1 : filt_delay;
        g = longint'(filt_gain);
        if (g > GAIN_LIMIT) g = GAIN_LIMIT;
        if (g < -GAIN_LIMIT) g = -GAIN_LIMIT;
        rd_ptr = ring_wr_ptr - d;
        y = round_to_sample(-g * longint'(x)) + longint'(x_ring[rd_ptr])
            + round_to_sample(g * longint'(y_ring[rd_ptr]));
        // The saturated value is what feeds back through the output ring.
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        x_ring[ring_wr_ptr] = x;
        y_ring[ring_wr_ptr] = y[SAMPLE_BITS-1:0];
        ring_wr_ptr = ring_wr_ptr + 12'd1;
        return y[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, driver and monitor.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] samples_to_send [$];
    logic signed [SAMPLE_BITS-1:0] expected_out [$];
    int  samples_queued = 0;
    int  beats_in       = 0;
    int  beats_out      = 0;
    int  mismatches     = 0;
    logic in_taken      = 1'b0;
    logic no_idle       = 1'b0;

    // ------------------------------------------------------------------
    // Input driver. Inputs change on the falling edge. A new beat is only
    // presented once the previous one was taken, so valid never drops
    // while a beat is pending. Random gaps come unless no_idle is set.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!no_idle && samples_to_send.size() > 0 &&
                         $urandom_range(0, 9) == 0) begin
                s_valid  <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end else if (samples_to_send.size() > 0) begin
                s_valid     <= 1'b1;
                s_sample_in <= samples_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver. Random stalls, plus one long hold-off while the sender
    // still has plenty queued, so the pipeline fills up and s_ready has to drop.
    // ------------------------------------------------------------------
    int  stall_left      = 0;
    logic long_hold_done = 1'b0;

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!long_hold_done && beats_out >= 200 &&
                     samples_to_send.size() > 20) begin
            m_ready        <= 1'b0;
            stall_left     <= 48;
            long_hold_done <= 1'b1;
        end else if (aresetn && !no_idle && $urandom_range(0, 9) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= aresetn;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard, sampled on the rising edge. Each input beat
    // steps the model; each result beat is checked against the oldest
    // expected sample.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic signed [SAMPLE_BITS-1:0] want;
        in_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("result beat %0d with no sample expected, got %0d",
                             beats_out, m_sample_out);
            end else begin
                want = expected_out.pop_front();
                if (m_sample_out !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result beat %0d: expected %0d, got %0d",
                                 beats_out, want, m_sample_out);
                end
            end
            beats_out = beats_out + 1;
        end
        if (aresetn && s_valid && s_ready) begin
            expected_out.push_back(allpass_next(s_sample_in));
            beats_in = beats_in + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Register write on the plain write port; the model takes the same
    // value at the edge where the block does.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_FILTER_ENABLE: filt_en    = val[0];
            CFG_DELAY_SAMPLES: filt_delay = val[DELAY_BITS-1:0];
            CFG_GAIN_COEFF:    filt_gain  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] x);
        samples_to_send.push_back(x);
        samples_queued = samples_queued + 1;
    endtask

    // Wait until every queued sample went in and every result came out,
    // then let the pipeline settle before the next step.
    task automatic drain();
        while (beats_in != samples_queued || expected_out.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($urandom_range(0, 64)) - 24'sd32;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Mostly short delays so the feedback path is exercised often.
    function automatic logic [CFG_BITS-1:0] random_delay();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_BITS'(RING_DEPTH - 1);
            2: return CFG_BITS'(1);
            3, 4, 5, 6: return CFG_BITS'($urandom_range(2, 16));
            default: return CFG_BITS'($urandom_range(0, RING_DEPTH - 1));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] random_gain();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return CFG_BITS'(GAIN_LIMIT);
            3: return CFG_BITS'(-GAIN_LIMIT);
            4: return '0;
            default: return CFG_BITS'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset state: filter off, so samples pass straight through.
        @(posedge aclk);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(24'sd0);
        queue_sample(-24'sd1);
        drain();

        // Filter on with the reset delay and gain; full-scale steps push
        // the sum past the top of the range.
        write_reg(CFG_FILTER_ENABLE, 16'd1);
        @(posedge aclk);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(24'sd0);
        queue_sample(24'sd1);
        queue_sample(-24'sd1);
        drain();

        // Gain of one half with a delay of zero, which acts as one. Odd
        // samples land exactly on the rounding midpoint.
        write_reg(CFG_GAIN_COEFF, 16'd16384);
        write_reg(CFG_DELAY_SAMPLES, 16'd0);
        @(posedge aclk);
        queue_sample(24'sd1);
        queue_sample(-24'sd1);
        queue_sample(24'sd3);
        queue_sample(-24'sd3);
        drain();

        // A write to the unmapped index must change nothing. Then the most
        // negative gain, which is clamped, driving the output into the rails.
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        write_reg(CFG_GAIN_COEFF, 16'h8000);
        @(posedge aclk);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        drain();

        // Most positive gain, also clamped, with the longest delay.
        write_reg(CFG_GAIN_COEFF, 16'h7FFF);
        write_reg(CFG_DELAY_SAMPLES, 16'(RING_DEPTH - 1));
        @(posedge aclk);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(24'sd5);
        drain();

        // Random phases: fresh settings each time, about a hundred samples
        // per phase. The last phase runs with no idling on either side.
        for (int ph = 0; ph < 8; ph++) begin
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNMAPPED, CFG_BITS'($urandom()));
            write_reg(CFG_FILTER_ENABLE,
                      ($urandom_range(0, 4) == 0) ? 16'd0 : 16'd1);
            write_reg(CFG_DELAY_SAMPLES, random_delay());
            write_reg(CFG_GAIN_COEFF, random_gain());
            @(posedge aclk);
            if (ph == 7)
                no_idle = 1'b1;
            repeat (100) queue_sample(random_sample());
            drain();
        end

        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("PASS schroeder_allpass_filter_unit");
        end else begin
            $display("FAIL schroeder_allpass_filter_unit");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this sequence.
    initial begin
        #4000000;
        $display("FAIL schroeder_allpass_filter_unit");
        $finish;
    end

endmodule

### schroeder_allpass_filter_unit.f
rtl/sap_pkg.sv
rtl/sap_ring_ram.sv
rtl/schroeder_allpass_filter_unit.sv
tb/sv/tb_schroeder_allpass_filter_unit.sv
